// ===== rtl/wcts_pkg.sv =====
package wcts_pkg;

    // Number of fixed word slots in one time phrase.
    localparam int NUM_SLOTS = 12;

    // Grid words, in the order of the word table.
    typedef enum logic [5:0] {
        W_ULDOT     = 6'd0,
        W_URDOT     = 6'd1,
        W_LLDOT     = 6'd2,
        W_LRDOT     = 6'd3,
        W_ITS       = 6'd4,
        W_A         = 6'd5,
        W_QUARTER   = 6'd6,
        W_HALF      = 6'd7,
        W_PAST      = 6'd8,
        W_TO        = 6'd9,
        W_FIVE_M    = 6'd10,
        W_TEN_M     = 6'd11,
        W_TWENTY_M  = 6'd12,
        W_NOON      = 6'd13,
        W_MIDNIGHT  = 6'd14,
        W_OCLOCK    = 6'd15,
        W_AT        = 6'd16,
        W_NIGHT     = 6'd17,
        W_IN        = 6'd18,
        W_THE       = 6'd19,
        W_MORNING   = 6'd20,
        W_AFTERNOON = 6'd21,
        W_EVENING   = 6'd22,
        W_HOUR1     = 6'd23,
        W_HOUR2     = 6'd24,
        W_HOUR3     = 6'd25,
        W_HOUR4     = 6'd26,
        W_HOUR5     = 6'd27,
        W_HOUR6     = 6'd28,
        W_HOUR7     = 6'd29,
        W_HOUR8     = 6'd30,
        W_HOUR9     = 6'd31,
        W_HOUR10    = 6'd32,
        W_HOUR11    = 6'd33
    } word_t;

    // One classified time: the word in each slot and which slots are lit.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        word_t [NUM_SLOTS-1:0] words;
    } slot_list_t;

    // First grid cell of a word.
    function automatic logic [7:0] span_start_of(input word_t w);
        logic [7:0] s;
        case (w)
            W_ULDOT:     s = 8'd0;
            W_URDOT:     s = 8'd15;
            W_LLDOT:     s = 8'd240;
            W_LRDOT:     s = 8'd255;
            W_ITS:       s = 8'd1;
            W_A:         s = 8'd5;
            W_QUARTER:   s = 8'd7;
            W_HALF:      s = 8'd32;
            W_PAST:      s = 8'd37;
            W_TO:        s = 8'd40;
            W_FIVE_M:    s = 8'd23;
            W_TEN_M:     s = 8'd27;
            W_TWENTY_M:  s = 8'd16;
            W_NOON:      s = 8'd119;
            W_MIDNIGHT:  s = 8'd72;
            W_OCLOCK:    s = 8'd97;
            W_AT:        s = 8'd112;
            W_NIGHT:     s = 8'd122;
            W_IN:        s = 8'd104;
            W_THE:       s = 8'd107;
            W_MORNING:   s = 8'd128;
            W_AFTERNOON: s = 8'd114;
            W_EVENING:   s = 8'd135;
            W_HOUR1:     s = 8'd48;
            W_HOUR2:     s = 8'd51;
            W_HOUR3:     s = 8'd54;
            W_HOUR4:     s = 8'd43;
            W_HOUR5:     s = 8'd64;
            W_HOUR6:     s = 8'd92;
            W_HOUR7:     s = 8'd59;
            W_HOUR8:     s = 8'd67;
            W_HOUR9:     s = 8'd88;
            W_HOUR10:    s = 8'd86;
            W_HOUR11:    s = 8'd80;
            default:     s = 8'd0;
        endcase
        return s;
    endfunction

    // Number of cells a word lights.
    function automatic logic [3:0] span_len_of(input word_t w);
        logic [3:0] n;
        case (w)
            W_ULDOT:     n = 4'd1;
            W_URDOT:     n = 4'd1;
            W_LLDOT:     n = 4'd1;
            W_LRDOT:     n = 4'd1;
            W_ITS:       n = 4'd3;
            W_A:         n = 4'd1;
            W_QUARTER:   n = 4'd7;
            W_HALF:      n = 4'd4;
            W_PAST:      n = 4'd4;
            W_TO:        n = 4'd2;
            W_FIVE_M:    n = 4'd4;
            W_TEN_M:     n = 4'd3;
            W_TWENTY_M:  n = 4'd6;
            W_NOON:      n = 4'd4;
            W_MIDNIGHT:  n = 4'd8;
            W_OCLOCK:    n = 4'd6;
            W_AT:        n = 4'd2;
            W_NIGHT:     n = 4'd5;
            W_IN:        n = 4'd2;
            W_THE:       n = 4'd3;
            W_MORNING:   n = 4'd7;
            W_AFTERNOON: n = 4'd9;
            W_EVENING:   n = 4'd7;
            W_HOUR1:     n = 4'd3;
            W_HOUR2:     n = 4'd3;
            W_HOUR3:     n = 4'd5;
            W_HOUR4:     n = 4'd4;
            W_HOUR5:     n = 4'd4;
            W_HOUR6:     n = 4'd3;
            W_HOUR7:     n = 4'd5;
            W_HOUR8:     n = 4'd5;
            W_HOUR9:     n = 4'd4;
            W_HOUR10:    n = 4'd3;
            W_HOUR11:    n = 4'd6;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/wcts_front.sv =====
module wcts_front
    import wcts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [10:0] minutes_of_day,
    input  logic       in_valid,
    output logic       in_ready,
    output slot_list_t list,
    output logic       list_valid,
    input  logic       list_ready
);

    // Reciprocals for the divisions by 60 and by 5; exact for all 11-bit inputs.
    localparam logic [11:0] HOUR_RECIP = 12'd2185;
    localparam int          HOUR_SHIFT = 17;
    localparam logic [13:0] Q5_RECIP   = 14'd13108;
    localparam int          Q5_SHIFT   = 16;

    // Fixed slot positions in the phrase.
    localparam int SLOT_ITS   = 0;
    localparam int SLOT_LL    = 1;
    localparam int SLOT_LR    = 2;
    localparam int SLOT_UR    = 3;
    localparam int SLOT_UL    = 4;
    localparam int SLOT_TOD1  = 5;
    localparam int SLOT_TOD2  = 6;
    localparam int SLOT_TOD3  = 7;
    localparam int SLOT_HOUR  = 8;
    localparam int SLOT_LINK  = 9;
    localparam int SLOT_MIN1  = 10;
    localparam int SLOT_MIN2  = 11;

    logic [10:0] t_reg;
    logic [5:0]  hour_reg;
    logic [8:0]  q5_reg;
    logic        a_valid_reg;
    logic        a_valid_next;

    logic [22:0] hour_prod;
    logic [24:0] q5_prod;
    logic        in_accept;
    logic        push;

    // First stage: divide by 60 and by 5 through reciprocal multiplies.
    assign hour_prod = 23'(minutes_of_day) * 23'(HOUR_RECIP);
    assign q5_prod   = 25'(minutes_of_day) * 25'(Q5_RECIP);

    assign push       = a_valid_reg && list_ready;
    assign in_ready   = !a_valid_reg || list_ready;
    assign in_accept  = in_valid && in_ready;
    assign list_valid = a_valid_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            t_reg    <= minutes_of_day;
            hour_reg <= hour_prod[HOUR_SHIFT +: 6];
            q5_reg   <= q5_prod[Q5_SHIFT +: 9];
        end
    end

    // Second stage: classify the time into the lit slots of the phrase.
    logic [8:0]  hour_x12;
    logic [8:0]  min_diff;
    logic [3:0]  minute;
    logic [10:0] q5_x5;
    logic [10:0] rem_diff;
    logic [2:0]  rem;
    logic        to_next;
    logic [5:0]  shown;
    logic        twelve;
    logic        night;
    logic [3:0]  h12;
    logic [3:0]  min_eff;

    always_comb
    begin
        hour_x12 = {hour_reg, 3'b000} + {1'b0, hour_reg, 2'b00};
        min_diff = q5_reg - hour_x12;
        minute   = min_diff[3:0];
        q5_x5    = {q5_reg, 2'b00} + {2'b00, q5_reg};
        rem_diff = t_reg - q5_x5;
        rem      = rem_diff[2:0];
        to_next  = (minute > 4'd6);
        shown    = hour_reg + {5'd0, to_next};
        twelve   = shown inside {6'd0, 6'd12, 6'd24};
        night    = (shown >= 6'd20);
        if (shown >= 6'd24)
        begin
            h12 = 4'(shown - 6'd24);
        end
        else if (shown >= 6'd12)
        begin
            h12 = 4'(shown - 6'd12);
        end
        else
        begin
            h12 = shown[3:0];
        end
        min_eff = to_next ? (4'd12 - minute) : minute;
    end

    // Fill each slot with its word and mark whether it is lit.
    always_comb
    begin
        list.mask  = '0;
        list.words = {NUM_SLOTS{W_ITS}};

        list.mask[SLOT_ITS]  = 1'b1;
        list.words[SLOT_ITS] = W_ITS;

        // Corner dots for the minutes past the five-minute mark.
        list.mask[SLOT_LL]  = (rem >= 3'd4);
        list.words[SLOT_LL] = W_LLDOT;
        list.mask[SLOT_LR]  = (rem >= 3'd3);
        list.words[SLOT_LR] = W_LRDOT;
        list.mask[SLOT_UR]  = (rem >= 3'd2);
        list.words[SLOT_UR] = W_URDOT;
        list.mask[SLOT_UL]  = (rem >= 3'd1);
        list.words[SLOT_UL] = W_ULDOT;

        // Time-of-day phrase.
        list.mask[SLOT_TOD1]  = !twelve;
        list.words[SLOT_TOD1] = night ? W_AT : W_IN;
        list.mask[SLOT_TOD2]  = !twelve;
        list.words[SLOT_TOD2] = night ? W_NIGHT : W_THE;
        list.mask[SLOT_TOD3]  = !twelve && !night;
        if (shown <= 6'd11)
        begin
            list.words[SLOT_TOD3] = W_MORNING;
        end
        else if (shown <= 6'd16)
        begin
            list.words[SLOT_TOD3] = W_AFTERNOON;
        end
        else
        begin
            list.words[SLOT_TOD3] = W_EVENING;
        end

        // Hour word.
        list.mask[SLOT_HOUR] = 1'b1;
        if (h12 == 4'd0)
        begin
            list.words[SLOT_HOUR] = (shown == 6'd0 || shown == 6'd24) ? W_MIDNIGHT : W_NOON;
        end
        else
        begin
            list.words[SLOT_HOUR] = word_t'(6'(W_HOUR1) + {2'b00, h12} - 6'd1);
        end

        // PAST, TO or O'CLOCK.
        if (minute == 4'd0)
        begin
            list.mask[SLOT_LINK]  = !twelve;
            list.words[SLOT_LINK] = W_OCLOCK;
        end
        else
        begin
            list.mask[SLOT_LINK]  = 1'b1;
            list.words[SLOT_LINK] = to_next ? W_TO : W_PAST;
        end

        // Five-minute words.
        list.mask[SLOT_MIN1] = (minute != 4'd0);
        list.mask[SLOT_MIN2] = (minute != 4'd0) && (min_eff == 4'd3 || min_eff == 4'd5);
        case (min_eff)
            4'd1:
            begin
                list.words[SLOT_MIN1] = W_FIVE_M;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
            4'd2:
            begin
                list.words[SLOT_MIN1] = W_TEN_M;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
            4'd3:
            begin
                list.words[SLOT_MIN1] = W_A;
                list.words[SLOT_MIN2] = W_QUARTER;
            end
            4'd4:
            begin
                list.words[SLOT_MIN1] = W_TWENTY_M;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
            4'd5:
            begin
                list.words[SLOT_MIN1] = W_TWENTY_M;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
            4'd6:
            begin
                list.words[SLOT_MIN1] = W_HALF;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
            default:
            begin
                list.words[SLOT_MIN1] = W_FIVE_M;
                list.words[SLOT_MIN2] = W_FIVE_M;
            end
        endcase
    end

endmodule

// ===== rtl/wcts_queue.sv =====
module wcts_queue
    import wcts_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_list_t wr_list,
    input  logic       wr_valid,
    output logic       wr_ready,
    output slot_list_t rd_list,
    output logic       rd_valid,
    input  logic       rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slot_list_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_list  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for the queued phrases.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_list;
        end
    end

endmodule

// ===== rtl/wcts_back.sv =====
module wcts_back
    import wcts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_list_t q_list,
    input  logic       q_valid,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_start,
    output logic [3:0] out_len,
    output logic       out_last
);

    logic                  busy_reg;
    logic [NUM_SLOTS-1:0]  mask_reg;
    word_t [NUM_SLOTS-1:0] words_reg;
    logic                  valid_reg;
    logic [7:0]            start_reg;
    logic [3:0]            len_reg;
    logic                  last_reg;

    logic [NUM_SLOTS-1:0]  src_mask;
    word_t [NUM_SLOTS-1:0] src_words;
    logic [NUM_SLOTS-1:0]  pick;
    logic [NUM_SLOTS-1:0]  remain;
    logic [5:0]            pick_bits;
    word_t                 pick_word;
    logic                  have;
    logic                  advance;

    // Work from the held phrase, or straight from the queue head when none is held.
    always_comb
    begin
        src_mask  = busy_reg ? mask_reg : q_list.mask;
        src_words = busy_reg ? words_reg : q_list.words;
        have      = busy_reg || q_valid;
        advance   = !valid_reg || out_ready;
        pick      = src_mask & (~src_mask + 1'b1);
        remain    = src_mask & (src_mask - 1'b1);
        pick_bits = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pick_bits = pick_bits | ({6{pick[i]}} & 6'(src_words[i]));
        end
        pick_word = word_t'(pick_bits);
        q_pop     = advance && !busy_reg && q_valid;
    end

    // Output register and phrase walker.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= have;
            if (have)
            begin
                busy_reg <= (remain != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && have)
        begin
            start_reg <= span_start_of(pick_word);
            len_reg   <= span_len_of(pick_word);
            last_reg  <= (remain == '0);
            mask_reg  <= remain;
            words_reg <= src_words;
        end
    end

    assign out_valid = valid_reg;
    assign out_start = start_reg;
    assign out_len   = len_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/word_clock_time_to_spans.sv =====
// Turns a time of day in minutes into the word spans to light on a 16 by 16
// word-clock grid, one span per output word, the final span of each time
// marked by m_tlast. A time yields 2 to 12 spans, and the output channel
// carries one span per cycle while m_tready is high; the front end takes a
// new time every cycle into a two-stage classifier that feeds a queue of
// QUEUE_DEPTH decoded phrases, so input is stalled only when that queue is
// full. A time is registered in the classifier, then in the queue, then in
// the output register on its way to the first span.
module word_clock_time_to_spans
    import wcts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] minutes_of_day, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] span_start, [11:8] span_length, [15:12] zero
    output logic        m_tlast    // last_span
);

    slot_list_t front_list;
    logic       front_valid;
    logic       front_ready;
    slot_list_t head_list;
    logic       head_valid;
    logic       head_pop;
    logic [7:0] span_start;
    logic [3:0] span_length;

    // Classification of each time into phrase slots.
    wcts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .minutes_of_day (s_tdata[10:0]),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .list           (front_list),
        .list_valid     (front_valid),
        .list_ready     (front_ready)
    );

    // Decoded phrases waiting for the output side.
    wcts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_list  (front_list),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_list  (head_list),
        .rd_valid (head_valid),
        .rd_pop   (head_pop)
    );

    // Span emission, one word per cycle while m_tready is high.
    wcts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_list    (head_list),
        .q_valid   (head_valid),
        .q_pop     (head_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_start (span_start),
        .out_len   (span_length),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, span_length, span_start};

endmodule

// ===== rtl/wcts_checker.sv =====
module wcts_checker
    import wcts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Set at the start of each phrase: after reset and after a final word.
    logic phrase_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phrase_start_reg <= 1'b1;
        end
        else if (m_tvalid && m_tready)
        begin
            phrase_start_reg <= m_tlast;
        end
    end

    // A stalled output word stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled output word keeps its contents.
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Every span has a length of one to nine cells and zero padding.
    a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[11:8] != 4'd0 && m_tdata[11:8] <= 4'd9
                     && m_tdata[15:12] == 4'd0)
        else $error("span length out of range");

    // Every phrase opens with ITS, which is never the final word.
    a_phrase_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && phrase_start_reg |->
            m_tdata[7:0] == span_start_of(W_ITS) && m_tdata[11:8] == span_len_of(W_ITS)
            && !m_tlast)
        else $error("phrase does not open with ITS");

    // No word is offered in the first cycle after reset.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output word right after reset");

endmodule

bind word_clock_time_to_spans wcts_checker u_wcts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/word_clock_time_to_spans_check.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the span generator. Every time word taken
// on the input side is turned into its expected list of spans, and every
// span word leaving the output side is compared with the oldest one waiting.
module word_clock_time_to_spans_check
    import wcts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] minutes_of_day, [15:11] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] span_start, [11:8] span_length, [15:12] zero
    input  logic        m_tlast,   // last_span
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0] start_cell;
        logic [3:0] cells;
        logic       last;
    } span_t;

    // Grid position and size of every word, indexed by word code.
    localparam logic [7:0] FIRST_CELL [34] = '{
        8'd0,   8'd15,  8'd240, 8'd255, 8'd1,   8'd5,   8'd7,   8'd32,
        8'd37,  8'd40,  8'd23,  8'd27,  8'd16,  8'd119, 8'd72,  8'd97,
        8'd112, 8'd122, 8'd104, 8'd107, 8'd128, 8'd114, 8'd135,
        8'd48,  8'd51,  8'd54,  8'd43,  8'd64,  8'd92,  8'd59,  8'd67,
        8'd88,  8'd86,  8'd80
    };
    localparam logic [3:0] CELL_COUNT [34] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd7, 4'd4,
        4'd4, 4'd2, 4'd4, 4'd3, 4'd6, 4'd4, 4'd8, 4'd6,
        4'd2, 4'd5, 4'd2, 4'd3, 4'd7, 4'd9, 4'd7,
        4'd3, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd5,
        4'd4, 4'd3, 4'd6
    };

    span_t expected_spans[$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Builds the phrase for one time of day and queues its spans.
    function automatic void queue_phrase(input logic [10:0] t);
        word_t       words[$];
        int unsigned rem;
        int unsigned hour;
        int unsigned fives;
        int unsigned shown;
        int unsigned h12;
        int          count;
        logic        noon_or_midnight;
        span_t       s;
        rem   = t % 5;
        hour  = t / 60;
        fives = (t % 60) / 5;
        shown = hour;
        words.push_back(W_ITS);

        // Corner dots for the minutes past the last five-minute mark.
        if (rem >= 4) words.push_back(W_LLDOT);
        if (rem >= 3) words.push_back(W_LRDOT);
        if (rem >= 2) words.push_back(W_URDOT);
        if (rem >= 1) words.push_back(W_ULDOT);

        // From 35 minutes past the hour on, the phrase names the coming hour.
        if (fives > 6)
            shown++;
        noon_or_midnight = (shown == 0 || shown == 12 || shown == 24);

        if (!noon_or_midnight)
        begin
            if (shown >= 20)
            begin
                words.push_back(W_AT);
                words.push_back(W_NIGHT);
            end
            else
            begin
                words.push_back(W_IN);
                words.push_back(W_THE);
                if (shown <= 11)
                    words.push_back(W_MORNING);
                else if (shown <= 16)
                    words.push_back(W_AFTERNOON);
                else
                    words.push_back(W_EVENING);
            end
        end

        h12 = shown % 12;
        if (h12 == 0)
            words.push_back((shown == 0 || shown == 24) ? W_MIDNIGHT : W_NOON);
        else
            words.push_back(word_t'(int'(W_HOUR1) + h12 - 1));

        // Relation to the hour and the five-minute words.
        if (fives == 0)
        begin
            if (!noon_or_midnight)
                words.push_back(W_OCLOCK);
        end
        else
        begin
            if (fives <= 6)
                words.push_back(W_PAST);
            else
            begin
                words.push_back(W_TO);
                fives = 12 - fives;
            end
            case (fives)
                1: words.push_back(W_FIVE_M);
                2: words.push_back(W_TEN_M);
                3:
                begin
                    words.push_back(W_A);
                    words.push_back(W_QUARTER);
                end
                4: words.push_back(W_TWENTY_M);
                5:
                begin
                    words.push_back(W_TWENTY_M);
                    words.push_back(W_FIVE_M);
                end
                6: words.push_back(W_HALF);
                default: ;
            endcase
        end

        count = (words.size() > NUM_SLOTS) ? NUM_SLOTS : words.size();
        for (int i = 0; i < count; i++)
        begin
            s.start_cell = FIRST_CELL[int'(words[i])];
            s.cells      = CELL_COUNT[int'(words[i])];
            s.last       = (i == count - 1);
            expected_spans.push_back(s);
        end
    endfunction

    // Compare outgoing span words first, then queue the spans of a new time.
    always @(posedge clk)
    begin
        span_t want;
        span_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.start_cell = m_tdata[7:0];
                got.cells      = m_tdata[11:8];
                got.last       = m_tlast;
                if (expected_spans.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected span: start %0d length %0d last %0b",
                             $time, got.start_cell, got.cells, got.last);
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (got != want || m_tdata[15:12] != 4'd0)
                    begin
                        errors++;
                        $display("%0t: span mismatch: expected start %0d length %0d",
                                 $time, want.start_cell, want.cells,
                                 " last %0b pad 0, actual start %0d length %0d",
                                 want.last, got.start_cell, got.cells,
                                 " last %0b pad %0d", got.last, m_tdata[15:12]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                queue_phrase(s_tdata[10:0]);
            pending = expected_spans.size();
        end
    end

    // Spans still owed at the end are reported once the run stops.
    final
    begin
        if (expected_spans.size() != 0)
            $display("%0t: %0d expected spans never arrived", $time, expected_spans.size());
    end

endmodule

// ===== tb/word_clock_time_to_spans_test.sv =====
`timescale 1ns / 1ps

module word_clock_time_to_spans_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 140;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // [10:0] minutes_of_day, [15:11] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] span_start, [11:8] span_length, [15:12] zero
    logic        m_tlast;           // last_span

    int errors;
    int pending;
    int send_gap_pct = 23;
    int ready_stall_pct = 48;
    int cycle_count = 0;

    // Times that hit the extremes, all hour words but TWO, THREE and NINE,
    // every minute phrase, every part of the day and the times past the end of the day.
    localparam logic [10:0] DIRECTED_TIMES [23] = '{
        11'd0,    11'd720,  11'd1439, 11'd2047, 11'd1440, 11'd1380,
        11'd45,   11'd390,  11'd754,  11'd755,  11'd1017, 11'd1000,
        11'd965,  11'd611,  11'd1162, 11'd1228, 11'd60,   11'd1395,
        11'd1410, 11'd1415, 11'd715,  11'd1024, 11'd1023
    };

    word_clock_time_to_spans u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    word_clock_time_to_spans_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The span receiver stalls at random.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one time word after a random gap and waits until it is taken.
    // The valid stays high afterwards so that back-to-back words need no
    // second assignment in the same step.
    task automatic send_time(input logic [10:0] minutes);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, minutes};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Holds the input off until every expected span has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Mostly times within the day, some beyond it and some over the whole field.
    function automatic logic [10:0] random_time();
        case ($urandom_range(7))
            0:       return 11'($urandom_range(2047, 1440));
            1:       return 11'($urandom_range(2047, 0));
            default: return 11'($urandom_range(1439, 0));
        endcase
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_TIMES[i])
            send_time(DIRECTED_TIMES[i]);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_time(random_time());
        wait_drained();

        // Swap which side idles more.
        send_gap_pct    = 48;
        ready_stall_pct = 23;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_time(random_time());

        // Neither side idles.
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_time(random_time());
        wait_drained();

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
